FILE: src/csvfs_pkg.sv
// ----------------------------------------------------------------------------
// csvfs_pkg
// Shared types and byte constants of the CSV field splitter.
// ----------------------------------------------------------------------------
package csvfs_pkg;

  localparam logic [7:0] QUOTE_BYTE   = 8'h22;
  localparam logic [7:0] SPACE_BYTE   = 8'h20;
  localparam logic [7:0] TAB_BYTE     = 8'h09;
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0] SEP_RESET    = 8'd44;

  // Class of an incoming transaction, decided in the datapath.
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_RECORD,
    KIND_SEP,
    KIND_BLANK,
    KIND_DATA
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REP_RD,
    ST_REP_EMIT,
    ST_BYTE_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic rep_emit;
    logic byte_emit;
  } ctrl_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  has_pending;
    logic  char_full;
    logic  slot_free;
    logic  rep_last;
  } dp_status_t;

endpackage

FILE: src/csvfs_ram.sv
// ----------------------------------------------------------------------------
// csvfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csvfs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/csvfs_ctrl.sv
// ----------------------------------------------------------------------------
// csvfs_ctrl
// Sequencer: accepts bytes and steps through the replay of held blanks.
// ----------------------------------------------------------------------------
module csvfs_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  csvfs_pkg::dp_status_t sts,
  output csvfs_pkg::ctrl_cmd_t  cmd
);

  csvfs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csvfs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    logic go;
    go        = sts.char_full || sts.slot_free;
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      csvfs_pkg::ST_IDLE: begin
        in_ready   = sts.slot_free;
        cmd.accept = in_valid && sts.slot_free;
        if (cmd.accept && sts.kind == csvfs_pkg::KIND_DATA && sts.has_pending) begin
          state_nxt = csvfs_pkg::ST_REP_RD;
        end
      end
      csvfs_pkg::ST_REP_RD: begin
        state_nxt = csvfs_pkg::ST_REP_EMIT;
      end
      csvfs_pkg::ST_REP_EMIT: begin
        cmd.rep_emit = go;
        if (go) begin
          state_nxt = sts.rep_last ? csvfs_pkg::ST_BYTE_EMIT : csvfs_pkg::ST_REP_RD;
        end
      end
      csvfs_pkg::ST_BYTE_EMIT: begin
        cmd.byte_emit = go;
        if (go) begin
          state_nxt = csvfs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = csvfs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/csvfs_dp.sv
// ----------------------------------------------------------------------------
// csvfs_dp
// Line state, blank store and output register of the CSV field splitter.
// ----------------------------------------------------------------------------
module csvfs_dp #(
  parameter int CELL_CHARS  = 256,
  parameter int BLANK_DEPTH = 32,
  parameter int MAX_CELLS   = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [7:0]            cfg_wr_data,
  input  logic [7:0]            in_byte,
  input  logic                  in_end_of_input,
  input  csvfs_pkg::ctrl_cmd_t  cmd,
  output csvfs_pkg::dp_status_t sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_is_data,
  output logic                  out_cell_end,
  output logic                  out_record_end,
  output logic [5:0]            out_cell_index,
  output logic [7:0]            out_char_index,
  output logic                  out_truncated,
  output logic                  out_last_of_run
);

  localparam int CHAR_LIMIT = ((CELL_CHARS - 1) > 255) ? 255 : (CELL_CHARS - 1);
  localparam int CELL_LIMIT = (MAX_CELLS > 64) ? 63 : (MAX_CELLS - 1);
  localparam int CW         = $clog2(BLANK_DEPTH + 1);
  localparam int AW         = (BLANK_DEPTH > 1) ? $clog2(BLANK_DEPTH) : 1;

  logic [7:0]    sep_r, sep_nxt;
  logic          quoted_r, quoted_nxt;
  logic          started_r, started_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [5:0]    cell_r, cell_nxt;
  logic [7:0]    char_r, char_nxt;
  logic          ovf_r, ovf_nxt;
  logic          busy_r, busy_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic [7:0]    hold_r, hold_nxt;

  logic          ram_we;
  logic [0:0]    ram_wdata;
  logic [0:0]    ram_rdata;

  logic          ld, ld_data, ld_cend, ld_rend, ld_last;
  logic [7:0]    ld_byte;
  logic          is_blank;
  logic          char_full;

  csvfs_ram #(
    .WIDTH(1),
    .DEPTH(BLANK_DEPTH)
  ) u_blank_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_r[AW-1:0]),
    .wdata(ram_wdata),
    .raddr(idx_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  assign is_blank  = (in_byte == csvfs_pkg::SPACE_BYTE) || (in_byte == csvfs_pkg::TAB_BYTE);
  assign char_full = (char_r == 8'(CHAR_LIMIT));
  assign ram_wdata = (in_byte == csvfs_pkg::TAB_BYTE);

  always_comb begin
    if (in_end_of_input) begin
      sts.kind = busy_r ? csvfs_pkg::KIND_RECORD : csvfs_pkg::KIND_NONE;
    end else if (in_byte == csvfs_pkg::NEWLINE_BYTE) begin
      sts.kind = csvfs_pkg::KIND_RECORD;
    end else if (in_byte != csvfs_pkg::QUOTE_BYTE && in_byte == sep_r && !quoted_r &&
                 !(is_blank && !started_r)) begin
      sts.kind = csvfs_pkg::KIND_SEP;
    end else if (is_blank) begin
      sts.kind = csvfs_pkg::KIND_BLANK;
    end else begin
      sts.kind = csvfs_pkg::KIND_DATA;
    end
    sts.has_pending = (count_r != '0);
    sts.char_full   = char_full;
    sts.slot_free   = !ovalid_r || out_ready;
    sts.rep_last    = (({1'b0, idx_r} + 1'b1) == {1'b0, count_r});
  end

  always_comb begin
    sep_nxt     = cfg_wr_en ? cfg_wr_data : sep_r;
    quoted_nxt  = quoted_r;
    started_nxt = started_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    cell_nxt    = cell_r;
    char_nxt    = char_r;
    ovf_nxt     = ovf_r;
    busy_nxt    = busy_r;
    hold_nxt    = hold_r;
    ram_we      = 1'b0;
    ld          = 1'b0;
    ld_byte     = '0;
    ld_data     = 1'b0;
    ld_cend     = 1'b0;
    ld_rend     = 1'b0;
    ld_last     = 1'b0;

    if (cmd.accept) begin
      idx_nxt  = '0;
      hold_nxt = in_byte;
      case (sts.kind)
        csvfs_pkg::KIND_RECORD: begin
          ld          = 1'b1;
          ld_cend     = 1'b1;
          ld_rend     = 1'b1;
          ld_last     = 1'b1;
          started_nxt = 1'b0;
          count_nxt   = '0;
          char_nxt    = '0;
          ovf_nxt     = 1'b0;
          quoted_nxt  = 1'b0;
          cell_nxt    = '0;
          busy_nxt    = 1'b0;
        end
        csvfs_pkg::KIND_SEP: begin
          ld          = 1'b1;
          ld_cend     = 1'b1;
          ld_last     = 1'b1;
          started_nxt = 1'b0;
          count_nxt   = '0;
          char_nxt    = '0;
          ovf_nxt     = 1'b0;
          busy_nxt    = 1'b1;
          if (cell_r < 6'(CELL_LIMIT)) begin
            cell_nxt = cell_r + 6'd1;
          end
        end
        csvfs_pkg::KIND_BLANK: begin
          busy_nxt = 1'b1;
          // Blanks before the first non-blank byte of a cell are dropped.
          if (started_r) begin
            if (count_r < CW'(BLANK_DEPTH)) begin
              ram_we    = 1'b1;
              count_nxt = count_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
        csvfs_pkg::KIND_DATA: begin
          busy_nxt    = 1'b1;
          started_nxt = 1'b1;
          if (in_byte == csvfs_pkg::QUOTE_BYTE) begin
            quoted_nxt = !quoted_r;
          end
          // With blanks pending, the byte waits in hold_r until they are replayed.
          if (count_r == '0) begin
            if (!char_full) begin
              ld       = 1'b1;
              ld_byte  = in_byte;
              ld_data  = 1'b1;
              ld_last  = 1'b1;
              char_nxt = char_r + 8'd1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.rep_emit) begin
      idx_nxt = idx_r + 1'b1;
      if (!char_full) begin
        ld       = 1'b1;
        ld_byte  = ram_rdata[0] ? csvfs_pkg::TAB_BYTE : csvfs_pkg::SPACE_BYTE;
        ld_data  = 1'b1;
        // Nothing more of this run fits once the store fills with this blank.
        ld_last  = ((char_r + 8'd1) == 8'(CHAR_LIMIT));
        char_nxt = char_r + 8'd1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    if (cmd.byte_emit) begin
      count_nxt = '0;
      if (!char_full) begin
        ld       = 1'b1;
        ld_byte  = hold_r;
        ld_data  = 1'b1;
        ld_last  = 1'b1;
        char_nxt = char_r + 8'd1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    ovalid_nxt = ld ? 1'b1 : (out_ready ? 1'b0 : ovalid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r     <= csvfs_pkg::SEP_RESET;
      quoted_r  <= 1'b0;
      started_r <= 1'b0;
      count_r   <= '0;
      idx_r     <= '0;
      cell_r    <= '0;
      char_r    <= '0;
      ovf_r     <= 1'b0;
      busy_r    <= 1'b0;
      ovalid_r  <= 1'b0;
    end else begin
      sep_r     <= sep_nxt;
      quoted_r  <= quoted_nxt;
      started_r <= started_nxt;
      count_r   <= count_nxt;
      idx_r     <= idx_nxt;
      cell_r    <= cell_nxt;
      char_r    <= char_nxt;
      ovf_r     <= ovf_nxt;
      busy_r    <= busy_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    if (ld) begin
      out_byte        <= ld_byte;
      out_is_data     <= ld_data;
      out_cell_end    <= ld_cend;
      out_record_end  <= ld_rend;
      out_cell_index  <= cell_r;
      out_char_index  <= char_r;
      out_truncated   <= ovf_r;
      out_last_of_run <= ld_last;
    end
  end

  assign out_valid = ovalid_r;

endmodule

FILE: src/csv_field_splitter.sv
// ----------------------------------------------------------------------------
// csv_field_splitter
// Splits a text line, one byte per transaction, into cells.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one byte or an end-of-input mark.
// Output channel (out_valid/out_ready) carries cell bytes and cell-end markers
// with cell and character indices; out_last_of_run flags the final result of
// one input transaction. The user must write the separator byte through
// cfg_wr_en and cfg_wr_data only while the block is idle; the block itself
// does not enforce this. The separator resets to a comma. Each result sits
// in one output register, so a result appears in the cycle after the
// transaction or replay step that produces it. A non-blank byte that
// follows held blanks waits in hold_r while each held blank is read from
// the blank store and emitted; then the byte is emitted and input resumes.
// A new transaction is taken only while the output register is empty or being
// drained in the same cycle, so a stalled receiver stalls the input after one
// result. Synchronous reset clears all line state, empties the output register
// and restores the separator; the blank store needs no clearing.
// ----------------------------------------------------------------------------
module csv_field_splitter #(
  parameter int CELL_CHARS  = 256,
  parameter int BLANK_DEPTH = 32,
  parameter int MAX_CELLS   = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_is_data,
  output logic       out_cell_end,
  output logic       out_record_end,
  output logic [5:0] out_cell_index,
  output logic [7:0] out_char_index,
  output logic       out_truncated,
  output logic       out_last_of_run
);

  csvfs_pkg::ctrl_cmd_t  cmd;
  csvfs_pkg::dp_status_t sts;

  csvfs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  csvfs_dp #(
    .CELL_CHARS (CELL_CHARS),
    .BLANK_DEPTH(BLANK_DEPTH),
    .MAX_CELLS  (MAX_CELLS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_byte        (in_byte),
    .in_end_of_input(in_end_of_input),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_is_data    (out_is_data),
    .out_cell_end   (out_cell_end),
    .out_record_end (out_record_end),
    .out_cell_index (out_cell_index),
    .out_char_index (out_char_index),
    .out_truncated  (out_truncated),
    .out_last_of_run(out_last_of_run)
  );

endmodule

FILE: src/csvfs_checker.sv
// ----------------------------------------------------------------------------
// csvfs_checker
// Port-level checks of the CSV field splitter, bound to the top level.
// ----------------------------------------------------------------------------
module csvfs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       cfg_wr_en,
  input logic [7:0] cfg_wr_data,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_byte,
  input logic       in_end_of_input,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_is_data,
  input logic       out_cell_end,
  input logic       out_record_end,
  input logic [5:0] out_cell_index,
  input logic [7:0] out_char_index,
  input logic       out_truncated,
  input logic       out_last_of_run
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_cell_end) && $stable(out_char_index))
    else $error("output transaction changed while stalled");

  a_data_or_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_data && out_cell_end) && (out_is_data || out_cell_end))
    else $error("result is neither a data byte nor a cell marker");

  a_record_is_cell_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_end |-> out_cell_end)
    else $error("record end without cell end");

  a_marker_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_data |-> out_byte == 8'd0)
    else $error("marker carries a nonzero byte");

  // A marker is always the only result of its transaction.
  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cell_end |-> out_last_of_run)
    else $error("cell marker not flagged as last of run");

endmodule

bind csv_field_splitter csvfs_checker u_csvfs_checker (.*);

FILE: bench/tb_csv_field_splitter.sv
// ----------------------------------------------------------------------------
// tb_csv_field_splitter
// Self-checking bench for the CSV field splitter. Lines are built as queues
// of bytes, fed through the input channel with random gaps, and every result
// is checked against a cell tokenizer kept inside the bench. The separator is
// swept over several values between phases, the byte extremes among them.
// ----------------------------------------------------------------------------
module tb_csv_field_splitter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHAR_CAP   = 255;
  localparam int CELL_CAP   = 63;
  localparam int BLANK_CAP  = 32;
  localparam int SETTLE     = 80;
  localparam int IDLE_LIMIT = 3000;

  typedef struct {
    logic [7:0] data;
    logic       eoi;
  } line_item_t;

  typedef struct {
    logic [7:0] data;
    logic       is_data;
    logic       cell_end;
    logic       record_end;
    logic [5:0] cell_idx;
    logic [7:0] char_idx;
    logic       trunc;
    logic       last;
  } token_t;

  logic       clk;
  logic       rst_n           = 1'b0;
  logic       cfg_wr_en       = 1'b0;
  logic [7:0] cfg_wr_data     = 8'h00;
  logic       in_valid        = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte         = 8'h00;
  logic       in_end_of_input = 1'b0;
  logic       out_valid;
  logic       out_ready       = 1'b0;
  logic [7:0] out_byte;
  logic       out_is_data;
  logic       out_cell_end;
  logic       out_record_end;
  logic [5:0] out_cell_index;
  logic [7:0] out_char_index;
  logic       out_truncated;
  logic       out_last_of_run;

  csv_field_splitter DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_is_data     (out_is_data),
    .out_cell_end    (out_cell_end),
    .out_record_end  (out_record_end),
    .out_cell_index  (out_cell_index),
    .out_char_index  (out_char_index),
    .out_truncated   (out_truncated),
    .out_last_of_run (out_last_of_run)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  line_item_t line_bytes[$];
  token_t     due_tokens[$];
  int         n_queued     = 0;
  int         n_taken      = 0;
  int         phase_items  = 0;
  int         errors       = 0;
  int         gap_left     = 0;
  int         stall_left   = 0;
  int         quiet_cycles = 0;
  logic       in_taken     = 1'b0;
  logic       calm         = 1'b0;

  // Tokenizer state, mirrored from the block's line state.
  logic [7:0] sep_now;
  logic       quoted;
  logic       cell_started;
  logic       overflow;
  logic       line_busy;
  int         held_count;
  int         cell_no;
  int         char_no;
  logic       held_tab [BLANK_CAP];

  function automatic token_t make_token(logic [7:0] d, logic is_d, logic ce, logic re);
    token_t t;
    t.data       = d;
    t.is_data    = is_d;
    t.cell_end   = ce;
    t.record_end = re;
    t.cell_idx   = 6'(cell_no);
    t.char_idx   = 8'(char_no);
    t.trunc      = overflow;
    t.last       = 1'b0;
    return t;
  endfunction

  function automatic void clear_cell();
    cell_started = 1'b0;
    held_count   = 0;
    char_no      = 0;
    overflow     = 1'b0;
  endfunction

  function automatic void split_byte(logic [7:0] b, logic eoi);
    token_t run[$];
    logic   blank;
    blank = (b == csvfs_pkg::SPACE_BYTE) || (b == csvfs_pkg::TAB_BYTE);
    if (eoi || b == csvfs_pkg::NEWLINE_BYTE) begin
      if (eoi && !line_busy) return;
      run.push_back(make_token(8'h00, 1'b0, 1'b1, 1'b1));
      clear_cell();
      quoted    = 1'b0;
      cell_no   = 0;
      line_busy = 1'b0;
    end else begin
      line_busy = 1'b1;
      if (b != csvfs_pkg::QUOTE_BYTE && b == sep_now && !quoted &&
          !(blank && !cell_started)) begin
        run.push_back(make_token(8'h00, 1'b0, 1'b1, 1'b0));
        clear_cell();
        if (cell_no < CELL_CAP) cell_no++;
      end else if (blank) begin
        // Leading blanks vanish; later ones wait for the next non-blank byte.
        if (cell_started) begin
          if (held_count < BLANK_CAP) begin
            held_tab[held_count] = (b == csvfs_pkg::TAB_BYTE);
            held_count++;
          end else begin
            overflow = 1'b1;
          end
        end
      end else begin
        cell_started = 1'b1;
        if (b == csvfs_pkg::QUOTE_BYTE) quoted = !quoted;
        for (int i = 0; i < held_count; i++) begin
          if (char_no < CHAR_CAP) begin
            run.push_back(make_token(held_tab[i] ? csvfs_pkg::TAB_BYTE : csvfs_pkg::SPACE_BYTE,
                                     1'b1, 1'b0, 1'b0));
            char_no++;
          end else begin
            overflow = 1'b1;
          end
        end
        held_count = 0;
        if (char_no < CHAR_CAP) begin
          run.push_back(make_token(b, 1'b1, 1'b0, 1'b0));
          char_no++;
        end else begin
          overflow = 1'b1;
        end
      end
    end
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) due_tokens.push_back(run[i]);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Line building.
  function automatic void put(logic [7:0] b, logic eoi);
    line_item_t it;
    it.data = b;
    it.eoi  = eoi;
    line_bytes.push_back(it);
    n_queued++;
    phase_items++;
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put(s[i], 1'b0);
  endfunction

  function automatic void put_end();
    put(8'($urandom_range(0, 255)), 1'b1);
  endfunction

  function automatic void put_blank();
    put($urandom_range(0, 1) ? csvfs_pkg::TAB_BYTE : csvfs_pkg::SPACE_BYTE, 1'b0);
  endfunction

  function automatic logic [7:0] content_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == sep_now || b == csvfs_pkg::SPACE_BYTE || b == csvfs_pkg::TAB_BYTE ||
               b == csvfs_pkg::NEWLINE_BYTE || b == csvfs_pkg::QUOTE_BYTE);
    return b;
  endfunction

  function automatic void add_cell();
    int chunks;
    repeat ($urandom_range(0, 2)) put_blank();
    chunks = $urandom_range(0, 3);
    repeat (chunks) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          repeat ($urandom_range(1, 4)) put(content_byte(), 1'b0);
        end
        6, 7: begin
          // Quoted run holding a separator; now and then the closing quote is missing.
          put(csvfs_pkg::QUOTE_BYTE, 1'b0);
          repeat ($urandom_range(0, 2)) put(content_byte(), 1'b0);
          put(sep_now, 1'b0);
          put(content_byte(), 1'b0);
          if ($urandom_range(0, 3) != 0) put(csvfs_pkg::QUOTE_BYTE, 1'b0);
        end
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(33, 36)) put_blank();
            put(content_byte(), 1'b0);
          end else begin
            repeat ($urandom_range(1, 3)) put_blank();
          end
        end
      endcase
    end
    repeat ($urandom_range(0, 2)) put_blank();
  endfunction

  function automatic void add_line();
    int cells;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      return;
    end
    cells = $urandom_range(1, 4);
    for (int c = 0; c < cells; c++) begin
      add_cell();
      if (c < cells - 1) put(sep_now, 1'b0);
    end
    if ($urandom_range(0, 2) == 0) put_end();
    else put(csvfs_pkg::NEWLINE_BYTE, 1'b0);
    if ($urandom_range(0, 7) == 0) put_end();
  endfunction

  function automatic void fill(int budget);
    phase_items = 0;
    while (phase_items < budget) add_line();
  endfunction

  task automatic drain();
    while (n_taken != n_queued || due_tokens.size() != 0) @(negedge clk);
  endtask

  task automatic start_phase(logic [7:0] v);
    drain();
    repeat (SETTLE) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    sep_now      = v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    calm         = ($urandom_range(0, 2) == 0);
  endtask

  // Input side: take the next byte once the current transaction is done.
  always @(negedge clk) begin : feed
    line_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (line_bytes.size() > 0) begin
        it = line_bytes.pop_front();
        in_byte         <= it.data;
        in_end_of_input <= it.eoi;
        in_valid        <= 1'b1;
        gap_left         = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      split_byte(in_byte, in_end_of_input);
      n_taken++;
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch_out
    token_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_tokens.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual byte %h cell_end %b",
                 $time, out_byte, out_cell_end);
        errors++;
      end else begin
        want = due_tokens.pop_front();
        check_field("out_byte", want.data, out_byte);
        check_field("out_is_data", 8'(want.is_data), 8'(out_is_data));
        check_field("out_cell_end", 8'(want.cell_end), 8'(out_cell_end));
        check_field("out_record_end", 8'(want.record_end), 8'(out_record_end));
        check_field("out_cell_index", 8'(want.cell_idx), 8'(out_cell_index));
        check_field("out_char_index", want.char_idx, out_char_index);
        check_field("out_truncated", 8'(want.trunc), 8'(out_truncated));
        check_field("out_last_of_run", 8'(want.last), 8'(out_last_of_run));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sep_now   = csvfs_pkg::SEP_RESET;
    quoted    = 1'b0;
    line_busy = 1'b0;
    cell_no   = 0;
    clear_cell();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed lines on the reset separator.
    put_end();
    put_text("\n");
    put_text(" \ta \tb ,");
    put_text("\",x\",");
    put(8'h00, 1'b0);
    put(8'hFF, 1'b0);
    put_text(" ");
    put_end();
    put_text(" \n");
    put_text("\"q\n");
    put_text("z");
    put_end();

    start_phase(8'h00);
    fill(5);
    start_phase(8'hFF);
    fill(5);
    start_phase(csvfs_pkg::QUOTE_BYTE);
    fill(5);
    start_phase(csvfs_pkg::SPACE_BYTE);
    fill(5);
    start_phase(csvfs_pkg::TAB_BYTE);
    fill(5);
    start_phase(csvfs_pkg::NEWLINE_BYTE);
    fill(5);
    start_phase(8'($urandom_range(0, 255)));
    fill(5);

    start_phase(csvfs_pkg::SEP_RESET);
    // Enough cells to saturate the cell index.
    repeat (66) put(sep_now, 1'b0);
    put(csvfs_pkg::NEWLINE_BYTE, 1'b0);
    // A cell that overruns the store, with held blanks lost at the boundary and
    // a dropped quote that still opens a quoted run.
    repeat (250) put(content_byte(), 1'b0);
    put_text("  ");
    repeat (4) put(content_byte(), 1'b0);
    repeat (3) put_blank();
    put_text("\",x\"\n");
    // Blank run longer than the blank buffer.
    put_text("w");
    repeat (35) put_blank();
    put_text("y");
    put_end();

    drain();
    repeat (SETTLE) @(negedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
